// ===== sv/gyro_yaw_integrator_top_defines.svh =====
// ----------------------------------------------------------------------------
// gyro_yaw_integrator_top_defines
// Assertion macros for the verification file of the yaw integrator.
// ----------------------------------------------------------------------------
`ifndef GYRO_YAW_INTEGRATOR_TOP_DEFINES_SVH
`define GYRO_YAW_INTEGRATOR_TOP_DEFINES_SVH

// Clocked check, masked while rst is high.
`define GYI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define GYI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/gyi_pkg.sv =====
// ----------------------------------------------------------------------------
// gyi_pkg
// Widths, gains, codes and control types of the gyro yaw integrator.
// ----------------------------------------------------------------------------
package gyi_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int ANGLE_BITS = 32;

  localparam int RAW_W    = 16;
  localparam int FILT_W   = RAW_W + FRAC_BITS + 2;
  localparam int DIFF_W   = FILT_W + 1;
  localparam int CNT_W    = 13;
  localparam int MAX_BIAS = 4096;
  localparam int ACC_W    = FILT_W + 12;
  localparam int DIV_CNT_W = 6;

  localparam int PERIOD_W = 8;
  localparam int DZ_W     = 15;
  localparam int CFG_W    = 15;
  localparam int IDX_W    = 2;
  localparam int ACT_W    = 2;

  localparam int GAIN_W   = 32;
  localparam int YAWG_W   = 24;
  localparam int ALPHA_W  = 15;
  localparam int RGAIN_W  = 18;
  localparam int CDEG_W   = 17;

  localparam int FPROD_W  = DIFF_W + ALPHA_W;
  localparam int YPROD_W  = DIFF_W + GAIN_W + 1;
  localparam int RPROD_W  = DIFF_W + RGAIN_W;
  localparam int CPROD_W  = ANGLE_BITS + CDEG_W;

  localparam int YAW_SH   = FRAC_BITS + 48 - ANGLE_BITS;
  localparam int RATE_SH  = FRAC_BITS + 16;

  localparam int YAW_OUT_W  = 16;
  localparam int RATE_OUT_W = 18;
  localparam int OUT_W      = 40;
  localparam int OUT_PAD    = OUT_W - YAW_OUT_W - RATE_OUT_W - 1;

  localparam logic signed [ALPHA_W-1:0] ALPHA_Q16    = 15'sd6554;
  localparam logic        [YAWG_W-1:0]  YAW_GAIN_Q16 = 24'd11044871;
  localparam logic signed [RGAIN_W-1:0] RATE_GAIN_Q16 = 18'sd93617;
  localparam logic signed [CDEG_W-1:0]  CDEG_SCALE   = 17'sd36000;

  typedef enum logic [ACT_W-1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_CLR_YAW = 2'd1,
    ACT_RECAL   = 2'd2
  } act_t;

  typedef enum logic [IDX_W-1:0] {
    REG_PERIOD    = 2'd0,
    REG_BIAS_CNT  = 2'd1,
    REG_DEAD_ZONE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic take;
    logic clr_yaw;
    logic recal;
    logic filt_mul;
    logic filt_upd;
    logic acc;
    logic div_load;
    logic bias_set;
    logic comp;
    logic dz;
    logic mul;
    logic integ;
    logic scale;
    logic out_load;
  } gyi_cmd_t;

  typedef struct packed {
    logic calibrated;
    logic cal_hit;
    logic div_busy;
    logic out_free;
  } gyi_stat_t;

endpackage

// ===== sv/gyi_div.sv =====
// ----------------------------------------------------------------------------
// gyi_div
// Restoring divider, one quotient bit per cycle, for the bias average.
// ----------------------------------------------------------------------------
module gyi_div
  import gyi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [ACC_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             busy,
  output logic [ACC_W-1:0] quotient
);

  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CNT_W:0]       trial;
  logic                 fits;

  assign trial = {rem, quotient[ACC_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(ACC_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= CNT_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[CNT_W-1:0];
      end
      quotient <= {quotient[ACC_W-2:0], fits};
    end
  end

endmodule

// ===== sv/gyi_dp.sv =====
// ----------------------------------------------------------------------------
// gyi_dp
// Datapath: filter, bias calibration, dead zone, yaw integration, scaling.
// ----------------------------------------------------------------------------
module gyi_dp
  import gyi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  gyi_cmd_t         cmd,
  output gyi_stat_t        stat,
  input  logic [RAW_W-1:0] s_tdata,
  input  logic             cfg_valid,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  // configuration
  logic [PERIOD_W-1:0] period;
  logic [CNT_W-1:0]    bias_cnt;
  logic [DZ_W-1:0]     dead_zone;

  // model state
  logic [RAW_W-1:0]         raw_q;
  logic signed [FILT_W-1:0] filt;
  logic                     seeded;
  logic                     calibrated;
  logic signed [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]         count;
  logic signed [FILT_W-1:0] bias;
  logic                     bias_neg;
  logic [ANGLE_BITS-1:0]    yaw;
  logic signed [RATE_OUT_W-1:0] rate;

  // stage registers
  logic signed [FPROD_W-1:0] fprod;
  logic signed [DIFF_W-1:0]  c;
  logic signed [DIFF_W-1:0]  cdz;
  logic [GAIN_W-1:0]         gain;
  logic signed [YPROD_W-1:0] yprod;
  logic signed [RPROD_W-1:0] rprod;
  logic signed [CPROD_W-1:0] cprod;

  logic signed [DIFF_W-1:0]  x_ext;
  logic signed [DIFF_W-1:0]  fdiff;
  logic [FPROD_W-1:0]        fround;
  logic [CNT_W-1:0]          tgt;
  logic [ACC_W-1:0]          half_ext;
  logic [ACC_W-1:0]          dividend;
  logic [ACC_W-1:0]          quotient;
  logic                      div_busy;
  logic signed [DIFF_W-1:0]  thr;
  logic                      in_dz;
  logic [YPROD_W-1:0]        yround;
  logic [RPROD_W-1:0]        rround;
  logic [CPROD_W-1:0]        cround;
  logic signed [FILT_W-1:0]  qs;

  assign x_ext  = DIFF_W'($signed({raw_q, {FRAC_BITS{1'b0}}}));
  assign fdiff  = x_ext - DIFF_W'(filt);
  assign fround = fprod + FPROD_W'(32'd32768);

  // 0 counts as 1, anything above the maximum as the maximum
  always_comb begin
    if (bias_cnt == '0) begin
      tgt = CNT_W'(1);
    end else if (bias_cnt > CNT_W'(MAX_BIAS)) begin
      tgt = CNT_W'(MAX_BIAS);
    end else begin
      tgt = bias_cnt;
    end
  end

  assign half_ext = ACC_W'(count >> 1);
  assign dividend = acc[ACC_W-1] ? (half_ext - $unsigned(acc))
                                 : ($unsigned(acc) + half_ext);
  assign qs = $signed(quotient[FILT_W-1:0]);

  assign thr   = $signed(DIFF_W'({dead_zone, {FRAC_BITS{1'b0}}}));
  assign in_dz = (c < thr) && (c > -thr);

  assign yround = yprod + YPROD_W'(64'd1 << (YAW_SH - 1));
  assign rround = rprod + {{(RPROD_W - RATE_SH){1'b0}}, {RATE_SH{rprod[RPROD_W-1]}}};
  assign cround = cprod + {{(CPROD_W - ANGLE_BITS){1'b0}}, {ANGLE_BITS{cprod[CPROD_W-1]}}};

  assign stat.calibrated = calibrated;
  assign stat.cal_hit    = ({1'b0, count} + 1'b1) >= {1'b0, tgt};
  assign stat.div_busy   = div_busy;
  assign stat.out_free   = !m_tvalid || m_tready;

  gyi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.div_load),
    .dividend (dividend),
    .divisor  (count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= PERIOD_W'(5);
      bias_cnt  <= CNT_W'(256);
      dead_zone <= DZ_W'(201);
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_PERIOD:    period    <= cfg_data[PERIOD_W-1:0];
        REG_BIAS_CNT:  bias_cnt  <= cfg_data[CNT_W-1:0];
        REG_DEAD_ZONE: dead_zone <= cfg_data[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt       <= '0;
      seeded     <= 1'b0;
      calibrated <= 1'b0;
      acc        <= '0;
      count      <= '0;
      bias       <= '0;
      yaw        <= '0;
      rate       <= '0;
    end else begin
      if (cmd.filt_upd) begin
        if (!seeded) begin
          filt   <= FILT_W'(x_ext);
          seeded <= 1'b1;
        end else begin
          filt <= filt + $signed(fround[FILT_W+15:16]);
        end
      end
      if (cmd.acc) begin
        acc   <= acc + ACC_W'(filt);
        count <= count + 1'b1;
      end
      if (cmd.recal) begin
        calibrated <= 1'b0;
        acc        <= '0;
        count      <= '0;
      end
      if (cmd.bias_set) begin
        bias       <= bias_neg ? -qs : qs;
        calibrated <= 1'b1;
      end
      if (cmd.integ) begin
        yaw  <= yaw + yround[YAW_SH+ANGLE_BITS-1:YAW_SH];
        rate <= $signed(rround[RATE_SH+RATE_OUT_W-1:RATE_SH]);
      end
      if (cmd.clr_yaw || cmd.bias_set) begin
        yaw  <= '0;
        rate <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      raw_q <= s_tdata;
    end
    if (cmd.filt_mul) begin
      fprod <= FPROD_W'(fdiff) * FPROD_W'(ALPHA_Q16);
    end
    if (cmd.div_load) begin
      bias_neg <= acc[ACC_W-1];
    end
    if (cmd.comp) begin
      c    <= DIFF_W'(filt) - DIFF_W'(bias);
      gain <= GAIN_W'(period) * GAIN_W'(YAW_GAIN_Q16);
    end
    if (cmd.dz) begin
      cdz <= in_dz ? '0 : c;
    end
    if (cmd.mul) begin
      yprod <= YPROD_W'(cdz) * $signed({1'b0, gain});
      rprod <= RPROD_W'(cdz) * RPROD_W'(RATE_GAIN_Q16);
    end
    if (cmd.scale) begin
      cprod <= CPROD_W'($signed(yaw)) * CPROD_W'(CDEG_SCALE);
    end
  end

  // output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {{OUT_PAD{1'b0}}, calibrated, rate,
                  cround[ANGLE_BITS+YAW_OUT_W-1:ANGLE_BITS]};
    end
  end

endmodule

// ===== sv/gyi_ctrl.sv =====
// ----------------------------------------------------------------------------
// gyi_ctrl
// Sequencer: steps the datapath through one action per accepted beat.
// ----------------------------------------------------------------------------
module gyi_ctrl
  import gyi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [ACT_W-1:0] s_tuser,
  input  gyi_stat_t        stat,
  output gyi_cmd_t         cmd
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_FILT  = 13'b0000000000010,
    S_FUPD  = 13'b0000000000100,
    S_ACC   = 13'b0000000001000,
    S_DIVLD = 13'b0000000010000,
    S_DIV   = 13'b0000000100000,
    S_BIAS  = 13'b0000001000000,
    S_COMP  = 13'b0000010000000,
    S_DZ    = 13'b0000100000000,
    S_MUL   = 13'b0001000000000,
    S_INTEG = 13'b0010000000000,
    S_SCALE = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.take = 1'b1;
          case (act_t'(s_tuser))
            ACT_SAMPLE: begin
              state_next = S_FILT;
            end
            ACT_CLR_YAW: begin
              cmd.clr_yaw = 1'b1;
              state_next  = S_SCALE;
            end
            ACT_RECAL: begin
              cmd.recal  = 1'b1;
              state_next = S_SCALE;
            end
            default: begin
              state_next = S_SCALE;
            end
          endcase
        end
      end
      S_FILT: begin
        cmd.filt_mul = 1'b1;
        state_next   = S_FUPD;
      end
      S_FUPD: begin
        cmd.filt_upd = 1'b1;
        state_next   = stat.calibrated ? S_COMP : S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = stat.cal_hit ? S_DIVLD : S_SCALE;
      end
      S_DIVLD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_BIAS;
        end
      end
      S_BIAS: begin
        cmd.bias_set = 1'b1;
        state_next   = S_SCALE;
      end
      S_COMP: begin
        cmd.comp   = 1'b1;
        state_next = S_DZ;
      end
      S_DZ: begin
        cmd.dz     = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_INTEG;
      end
      S_INTEG: begin
        cmd.integ  = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // wait for room in the output register
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/gyro_yaw_integrator_top.sv =====
// ----------------------------------------------------------------------------
// gyro_yaw_integrator_top
// Bias-calibrated yaw integration of a z-rate gyro, fixed point.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tuser: action; tdata: raw_rate
//   m_*      out  m_tvalid/m_tready    tdata: yaw_cdeg, rate_cdeg, ready_res
//   cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One beat at a time through a sequencer and a shared datapath.
// A sample takes a longer path while integrating than while calibrating;
// the sample that completes calibration also waits for the bit-serial
// bias divider. Yaw reset, recalibrate and unused actions go to scaling.
// A stalled output holds in its register; the next beat is taken meanwhile.
// rst is synchronous and restores the register defaults and calibrating state.
// ----------------------------------------------------------------------------
module gyro_yaw_integrator_top
  import gyi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [RAW_W-1:0] s_tdata,   // [15:0] raw_rate
  input  logic [ACT_W-1:0] s_tuser,   // [1:0] action
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // [15:0] yaw_cdeg, [33:16] rate_cdeg,
                                      // [34] ready_res, [39:35] zero
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  gyi_cmd_t  cmd;
  gyi_stat_t stat;

  assign cfg_ready = 1'b1;

  gyi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  gyi_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== sv/gyi_checker.sv =====
// ----------------------------------------------------------------------------
// gyi_checker
// Port-level checks on the yaw integrator, bound to the top level.
// ----------------------------------------------------------------------------
`include "gyro_yaw_integrator_top_defines.svh"

module gyi_checker
  import gyi_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // a stalled result beat stays put
  `GYI_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat changed under stall")

  // reset leaves no result pending and the input open
  `GYI_ASSERT_ALWAYS(a_rst_clear, rst |=> !m_tvalid && s_tready, "reset did not clear the block")

  // a taken beat keeps the sequencer busy for at least the next cycle
  `GYI_ASSERT(a_busy_after_take, s_tvalid && s_tready |=> !s_tready, "input taken twice in a row")

endmodule

bind gyro_yaw_integrator_top gyi_checker u_gyi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
